[rtl/lqmq_pkg.sv]
// Shared types and constants for the linear queue with maximum query.
// Used by the sequencer and the top level; depends on nothing else.
package lqmq_pkg;

  // Queue geometry.
  localparam int DATA_W = 32;
  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Operation codes.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_MAX = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Data returned when the queue holds nothing.
  localparam logic signed [DATA_W-1:0] DATA_NONE = -32'sd1;

  // One input item.
  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
  } out_t;

  // Request to the entry memory.
  typedef struct packed {
    logic                     en;
    logic                     we;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] wdata;
  } mem_req_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

endpackage

[rtl/lqmq_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// Self-contained; no package dependency.
module lqmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/lqmq_ctrl.sv]
// Sequencer for the queue: head, tail and empty flag, memory requests,
// the find-maximum scan and the result register. Depends on lqmq_pkg.
module lqmq_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  lqmq_pkg::in_t                    in_data,
  output lqmq_pkg::mem_req_t               mem_req,
  input  logic signed [lqmq_pkg::DATA_W-1:0] rd_data,
  output logic                             out_valid,
  output lqmq_pkg::out_t                   out_data
);

  lqmq_pkg::state_t state_r, state_nxt;
  logic [lqmq_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [lqmq_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic                       empty_r, empty_nxt;
  logic [lqmq_pkg::IDX_W-1:0] cur_r, cur_nxt;
  logic signed [lqmq_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [lqmq_pkg::DATA_W-1:0] best;
  logic                       out_valid_r, out_valid_nxt;
  lqmq_pkg::out_t             out_r, out_nxt;

  // The first entry of a scan seeds the maximum; later ones compete.
  assign best = ((cur_r == head_r) || (rd_data > max_r)) ? rd_data : max_r;

  // Next state, memory requests and results.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    cur_nxt       = cur_r;
    max_nxt       = max_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_req       = '0;

    unique case (state_r)
      lqmq_pkg::S_IDLE: begin
        if (start) begin
          unique case (in_data.opcode)
            lqmq_pkg::OP_ENQ: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{data: '0, status: lqmq_pkg::STAT_OK};
              if (empty_r) begin
                // First item goes to slot zero.
                mem_req   = '{en: 1'b1, we: 1'b1, addr: '0, wdata: in_data.value};
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (tail_r == lqmq_pkg::LAST_IDX) begin
                out_nxt.status = lqmq_pkg::STAT_FULL;
              end else begin
                mem_req  = '{en: 1'b1, we: 1'b1, addr: tail_r + 1'b1,
                             wdata: in_data.value};
                tail_nxt = tail_r + 1'b1;
              end
            end
            lqmq_pkg::OP_DEQ, lqmq_pkg::OP_MAX: begin
              if (empty_r) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: lqmq_pkg::DATA_NONE, status: lqmq_pkg::STAT_EMPTY};
              end else begin
                // Fetch the head entry; the result follows from the read data.
                mem_req   = '{en: 1'b1, we: 1'b0, addr: head_r, wdata: '0};
                cur_nxt   = head_r;
                state_nxt = (in_data.opcode == lqmq_pkg::OP_DEQ) ?
                            lqmq_pkg::S_DEQ : lqmq_pkg::S_SCAN;
              end
            end
            default: begin
              // Unused opcode: no change, plain ok result.
              out_valid_nxt = 1'b1;
              out_nxt       = '{data: '0, status: lqmq_pkg::STAT_OK};
            end
          endcase
        end
      end

      lqmq_pkg::S_DEQ: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{data: rd_data, status: lqmq_pkg::STAT_OK};
        state_nxt     = lqmq_pkg::S_IDLE;
        if (head_r == tail_r) begin
          // Last item left: back to an empty queue at slot zero.
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else begin
          head_nxt = head_r + 1'b1;
        end
      end

      lqmq_pkg::S_SCAN: begin
        max_nxt = best;
        if (cur_r == tail_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{data: best, status: lqmq_pkg::STAT_OK};
          state_nxt     = lqmq_pkg::S_IDLE;
        end else begin
          // Read the next entry while this one is compared.
          mem_req = '{en: 1'b1, we: 1'b0, addr: cur_r + 1'b1, wdata: '0};
          cur_nxt = cur_r + 1'b1;
        end
      end

      default: begin
        state_nxt = lqmq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqmq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan position, running maximum and result payload.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    max_r <= max_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != lqmq_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/linear_queue_with_max_query.sv]
// Top level of the array queue with find-maximum: entry memory and sequencer.
// Depends on lqmq_pkg, lqmq_ram and lqmq_ctrl.
//
//   channel   ports                      handshake
//   input     start, busy, in_data       taken when start is high and busy is low
//   result    out_valid, out_data        out_valid high for one cycle, always taken
//
// Enqueue, an unused opcode and any operation on an empty queue are answered
// from idle: the result appears the cycle after the item is taken. Dequeue reads
// the head entry and answers from the dequeue state. Find-maximum scans head to
// tail through the single memory port, one entry per cycle to the comparator.
// Reset empties the queue; the memory is not cleared and is only read where written.
// The receiver cannot stall; busy is low again in the cycle the result is shown.
module linear_queue_with_max_query (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lqmq_pkg::in_t in_data,
  output logic          out_valid,
  output lqmq_pkg::out_t out_data
);

  lqmq_pkg::mem_req_t                 mem_req;
  logic signed [lqmq_pkg::DATA_W-1:0] rd_data;

  // Entry storage. A write lands at the edge that takes its item, so any later
  // read of that slot comes in a later cycle and needs no forwarding.
  lqmq_ram #(
    .WIDTH(lqmq_pkg::DATA_W),
    .DEPTH(lqmq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rd_data)
  );

  // Queue sequencer.
  lqmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An enqueue always answers in the next cycle.
  a_enq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == lqmq_pkg::OP_ENQ) |=> out_valid)
    else $error("enqueue result not delivered in the next cycle");

  // A full status only answers an enqueue taken in the previous cycle.
  a_full_from_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == lqmq_pkg::STAT_FULL) |->
      $past(start && !busy && in_data.opcode == lqmq_pkg::OP_ENQ))
    else $error("full status without a matching enqueue");

  // An empty status always carries minus one.
  a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == lqmq_pkg::STAT_EMPTY) |->
      (out_data.data == lqmq_pkg::DATA_NONE))
    else $error("empty status with data other than minus one");

  // A result is shown only once the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an item is still at work");
`endif

endmodule
